@@ sv/ttac_pkg.sv @@
package ttac_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrBits = $clog2(QueueDepth);
  localparam int unsigned QueueCntBits = $clog2(QueueDepth + 1);

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_M        = 8'h6D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] FINAL_LO    = 8'h40;
  localparam logic [7:0] FINAL_HI    = 8'h7E;

  localparam logic [6:0] PARAM_MAX   = 7'd127;

  localparam logic [3:0] FG_RESET    = 4'd7;
  localparam logic [3:0] BG_RESET    = 4'd0;

  localparam logic [7:0] COLUMNS_RESET = 8'd80;
  localparam logic [7:0] ROWS_RESET    = 8'd25;

  localparam logic [7:0] CFG_COLUMNS = 8'd0;
  localparam logic [7:0] CFG_ROWS    = 8'd1;

  // SGR color number to attribute color
  localparam logic [2:0] COLOR_MAP [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_ESC    = 2'd1,
    PH_CSI    = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_TAB   = 2'd1,
    OP_NL    = 2'd2,
    OP_PRINT = 2'd3
  } op_t;

  typedef struct packed {
    logic [3:0] fg;
    logic [3:0] bg;
  } colors_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] glyph;
    logic [7:0] attr;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic colors_t sgr_apply(input logic [6:0] code, input colors_t c);
    colors_t    r;
    logic [6:0] off;
    r = c;
    off = '0;
    if (code == 7'd0 || code == 7'd22) begin
      r.fg = FG_RESET;
      r.bg = BG_RESET;
    end else if (code == 7'd1) begin
      r.fg = c.fg | 4'd8;
    end else if (code == 7'd2 || code == 7'd21) begin
      r.fg = c.fg & 4'd7;
    end else if (code == 7'd7 || code == 7'd27) begin
      r.fg = c.bg;
      r.bg = c.fg;
    end else if (code == 7'd39) begin
      r.fg = FG_RESET;
    end else if (code == 7'd49) begin
      r.bg = BG_RESET;
    end else if (code inside {[7'd30:7'd37]}) begin
      off = code - 7'd30;
      r.fg = {1'b0, COLOR_MAP[off[2:0]]};
    end else if (code inside {[7'd40:7'd47]}) begin
      off = code - 7'd40;
      r.bg = {1'b0, COLOR_MAP[off[2:0]]};
    end else if (code inside {[7'd90:7'd97]}) begin
      off = code - 7'd90;
      r.fg = {1'b1, COLOR_MAP[off[2:0]]};
    end else if (code inside {[7'd100:7'd107]}) begin
      off = code - 7'd100;
      r.bg = {1'b1, COLOR_MAP[off[2:0]]};
    end
    return r;
  endfunction

endpackage

@@ sv/ttac_front.sv @@
module ttac_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          byte_in,
  input  ttac_pkg::q_status_t q_status,
  output logic                push,
  output ttac_pkg::q_entry_t  entry
);
  import ttac_pkg::*;

  phase_t     phase, phase_next;
  logic [6:0] param_value, param_value_next;
  logic       param_closed, param_closed_next;
  colors_t    colors, colors_next;

  logic        print;
  logic [10:0] acc;
  logic [7:0]  digit;

  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_NORMAL;
      param_value  <= '0;
      param_closed <= 1'b0;
      colors       <= '{fg: FG_RESET, bg: BG_RESET};
    end else if (push) begin
      phase        <= phase_next;
      param_value  <= param_value_next;
      param_closed <= param_closed_next;
      colors       <= colors_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    param_value_next  = param_value;
    param_closed_next = param_closed;
    colors_next       = colors;
    print             = 1'b0;
    digit             = byte_in - CH_ZERO;
    acc               = ({4'b0, param_value} * 11'd10) + {3'b0, digit};
    entry.op          = OP_NONE;
    entry.glyph       = byte_in;
    entry.attr        = {colors.bg, colors.fg};

    case (phase)
      PH_ESC: begin
        if (byte_in == CH_LBRACKET) begin
          phase_next        = PH_CSI;
          param_value_next  = '0;
          param_closed_next = 1'b0;
        end else begin
          phase_next = PH_NORMAL;
          print      = 1'b1;
        end
      end
      PH_CSI: begin
        if (byte_in >= FINAL_LO && byte_in <= FINAL_HI) begin
          if (byte_in == CH_M) begin
            colors_next = sgr_apply(param_value, colors);
          end
          phase_next = PH_NORMAL;
        end else if (byte_in >= CH_ZERO && byte_in <= CH_NINE && !param_closed) begin
          param_value_next = (acc > {4'b0, PARAM_MAX}) ? PARAM_MAX : acc[6:0];
        end else begin
          param_closed_next = 1'b1;
        end
      end
      default: begin
        phase_next = PH_NORMAL;
        print      = 1'b1;
      end
    endcase

    if (print) begin
      case (byte_in)
        CH_NUL: entry.op = OP_NONE;
        CH_ESC: begin
          phase_next        = PH_ESC;
          param_value_next  = '0;
          param_closed_next = 1'b0;
        end
        CH_TAB:  entry.op = OP_TAB;
        CH_NL:   entry.op = OP_NL;
        default: entry.op = OP_PRINT;
      endcase
    end
  end

endmodule

@@ sv/ttac_fifo.sv @@
module ttac_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ttac_pkg::q_entry_t  din,
  input  logic                pop,
  output ttac_pkg::q_entry_t  dout,
  output ttac_pkg::q_status_t status
);
  import ttac_pkg::*;

  q_entry_t                  mem [QueueDepth];
  logic [QueuePtrBits-1:0]   wr_ptr;
  logic [QueuePtrBits-1:0]   rd_ptr;
  logic [QueueCntBits-1:0]   count;

  assign dout         = mem[rd_ptr];
  assign status.full  = (count == QueueCntBits'(QueueDepth));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QueuePtrBits'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QueuePtrBits'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ sv/ttac_back.sv @@
module ttac_back #(
  parameter int unsigned COORD_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          columns,
  input  logic [7:0]          rows,
  input  ttac_pkg::q_status_t q_status,
  input  ttac_pkg::q_entry_t  entry,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                write_cell,
  output logic [15:0]         cell_index,
  output logic [7:0]          glyph,
  output logic [7:0]          attribute,
  output logic                scroll_up,
  output logic [7:0]          cursor_column,
  output logic [7:0]          cursor_line
);
  import ttac_pkg::*;

  localparam logic [8:0] CoordMax = 9'((1 << COORD_BITS) - 1);

  logic [COORD_BITS-1:0] col_pos, col_pos_next;
  logic [COORD_BITS-1:0] row_pos, row_pos_next;

  logic [7:0]  cols, nrows, last_row;
  logic [8:0]  col_ext, row_ext, col9, row9;
  logic        wrap, row_inc, scroll;
  logic [15:0] index_calc;

  assign pop = !q_status.empty && (!out_valid || out_ready);

  always_comb begin
    cols       = (columns == '0) ? 8'd1 : columns;
    nrows      = (rows == '0) ? 8'd1 : rows;
    last_row   = nrows - 8'd1;
    col_ext    = 9'(col_pos);
    row_ext    = 9'(row_pos);
    index_calc = (16'(row_pos) * 16'(cols)) + 16'(col_pos);

    case (entry.op)
      OP_TAB:   col9 = (col_ext + 9'd8) & ~9'd7;
      OP_NL:    col9 = '0;
      OP_PRINT: col9 = col_ext + 9'd1;
      default:  col9 = col_ext;
    endcase

    wrap    = (entry.op != OP_NONE) && (col9 >= {1'b0, cols} || col9 > CoordMax);
    row_inc = (entry.op == OP_NL) || wrap;
    row9    = row_ext + {8'b0, row_inc};
    scroll  = (entry.op != OP_NONE) && (row9 >= {1'b0, nrows} || row9 > CoordMax);

    col_pos_next = wrap ? '0 : col9[COORD_BITS-1:0];
    if (scroll) begin
      row_pos_next = ({1'b0, last_row} > CoordMax) ? CoordMax[COORD_BITS-1:0]
                                                   : last_row[COORD_BITS-1:0];
    end else begin
      row_pos_next = row9[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      col_pos   <= '0;
      row_pos   <= '0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        col_pos   <= col_pos_next;
        row_pos   <= row_pos_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      write_cell    <= (entry.op == OP_PRINT);
      cell_index    <= (entry.op == OP_PRINT) ? index_calc : '0;
      glyph         <= (entry.op == OP_PRINT) ? entry.glyph : '0;
      attribute     <= (entry.op == OP_PRINT) ? entry.attr : '0;
      scroll_up     <= scroll;
      cursor_column <= 8'(col_pos_next);
      cursor_line   <= 8'(row_pos_next);
    end
  end

endmodule

@@ sv/text_terminal_with_ansi_color.sv @@
// Channel  Direction  Handshake              Beat contents
// in       input      in_valid / in_ready    byte_in
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
// out      output     out_valid / out_ready  write_cell, cell_index, glyph, attribute,
//                                            scroll_up, cursor_column, cursor_line
//
// One byte per cycle when out_ready holds; each passes the queue, then the output register.
// Front decodes escapes and colors, a two-entry queue feeds the back, which owns the cursor
// and the cell index multiply; the output register holds one result.
// Reset clears escape state, colors, cursor, queue and output valid; columns 80, rows 25.
// An output stall fills the queue, then in_ready drops. cfg_ready is always high.
module text_terminal_with_ansi_color #(
  parameter int unsigned COORD_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_in,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        write_cell,
  output logic [15:0] cell_index,
  output logic [7:0]  glyph,
  output logic [7:0]  attribute,
  output logic        scroll_up,
  output logic [7:0]  cursor_column,
  output logic [7:0]  cursor_line
);
  import ttac_pkg::*;

  logic [7:0] columns;
  logic [7:0] rows;
  logic       push;
  logic       pop;
  q_entry_t   q_in;
  q_entry_t   q_out;
  q_status_t  q_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= COLUMNS_RESET;
      rows    <= ROWS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COLUMNS: columns <= cfg_data;
        CFG_ROWS:    rows    <= cfg_data;
        default:     ;
      endcase
    end
  end

  ttac_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .byte_in  (byte_in),
    .q_status (q_status),
    .push     (push),
    .entry    (q_in)
  );

  ttac_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .din    (q_in),
    .pop    (pop),
    .dout   (q_out),
    .status (q_status)
  );

  ttac_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .columns       (columns),
    .rows          (rows),
    .q_status      (q_status),
    .entry         (q_out),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .write_cell    (write_cell),
    .cell_index    (cell_index),
    .glyph         (glyph),
    .attribute     (attribute),
    .scroll_up     (scroll_up),
    .cursor_column (cursor_column),
    .cursor_line   (cursor_line)
  );

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_status.empty |-> !pop)
    else $error("queue popped while empty");

  a_write_is_glyph: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_cell |->
      glyph != CH_NUL && glyph != CH_ESC && glyph != CH_TAB && glyph != CH_NL)
    else $error("control byte written as a glyph");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_cell |-> cell_index == '0 && glyph == '0 && attribute == '0)
    else $error("cell fields set without a write");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> {1'b0, cursor_column} < 9'(1 << COORD_BITS)
               && {1'b0, cursor_line} < 9'(1 << COORD_BITS))
    else $error("cursor beyond coordinate range");

  a_reset_clears_out: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule

@@ tb/sv/tb_text_terminal_with_ansi_color.sv @@
`timescale 1ns / 1ps

module tb_text_terminal_with_ansi_color;
  import ttac_pkg::*;

  localparam int CoordBits = 8;
  localparam int CoordMax = (1 << CoordBits) - 1;
  localparam int WatchdogLimit = 2000;
  localparam int HoldCycles = 150;
  localparam int PhaseBytes = 235;
  localparam int NumPhases = 8;

  // -1 picks a random size
  localparam int PhaseCols [NumPhases] = '{80, 1, 255, 1, 0, 8, 255, -1};
  localparam int PhaseRows [NumPhases] = '{25, 255, 255, 1, 0, 3, 1, -1};
  localparam int PhaseNl [NumPhases] = '{15, 10, 50, 15, 15, 15, 10, 15};

  localparam int SgrSpecial [9] = '{0, 1, 2, 7, 21, 22, 27, 39, 49};
  localparam logic [3:0] SgrToVga [8] = '{4'd0, 4'd4, 4'd2, 4'd6, 4'd1, 4'd5, 4'd3, 4'd7};

  typedef struct packed {
    logic        wr;
    logic [15:0] idx;
    logic [7:0]  gl;
    logic [7:0]  at;
    logic        scr;
    logic [7:0]  ccol;
    logic [7:0]  crow;
  } screen_update_t;

  typedef struct packed {
    logic [7:0]     b;
    logic           has_exp;
    screen_update_t exp;
  } dir_row_t;

  localparam screen_update_t NO_UPD = '0;

  localparam int DirRows = 23;
  localparam dir_row_t DIR_TAB [DirRows] = '{
    '{"A", 1'b1, '{1'b1, 16'd0, 8'h41, 8'h07, 1'b0, 8'd1, 8'd0}},
    '{CH_NUL, 1'b1, '{1'b0, 16'd0, 8'h00, 8'h00, 1'b0, 8'd1, 8'd0}},
    '{8'hFF, 1'b1, '{1'b1, 16'd1, 8'hFF, 8'h07, 1'b0, 8'd2, 8'd0}},
    '{CH_TAB, 1'b1, '{1'b0, 16'd0, 8'h00, 8'h00, 1'b0, 8'd8, 8'd0}},
    '{CH_NL, 1'b1, '{1'b0, 16'd0, 8'h00, 8'h00, 1'b0, 8'd0, 8'd1}},
    '{CH_ESC, 1'b1, '{1'b0, 16'd0, 8'h00, 8'h00, 1'b0, 8'd0, 8'd1}},
    '{"x", 1'b0, NO_UPD},
    '{CH_ESC, 1'b0, NO_UPD},
    '{CH_LBRACKET, 1'b0, NO_UPD},
    '{"4", 1'b0, NO_UPD},
    '{"4", 1'b0, NO_UPD},
    '{CH_M, 1'b0, NO_UPD},
    '{CH_ESC, 1'b0, NO_UPD},
    '{CH_LBRACKET, 1'b0, NO_UPD},
    '{"2", 1'b0, NO_UPD},
    '{"0", 1'b0, NO_UPD},
    '{"0", 1'b0, NO_UPD},
    '{";", 1'b0, NO_UPD},
    '{CH_M, 1'b0, NO_UPD},
    '{CH_ESC, 1'b0, NO_UPD},
    '{CH_ESC, 1'b0, NO_UPD},
    '{CH_LBRACKET, 1'b0, NO_UPD},
    '{"H", 1'b0, NO_UPD}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  byte_in;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        out_valid;
  logic        out_ready;
  logic        write_cell;
  logic [15:0] cell_index;
  logic [7:0]  glyph;
  logic [7:0]  attribute;
  logic        scroll_up;
  logic [7:0]  cursor_column;
  logic [7:0]  cursor_line;

  text_terminal_with_ansi_color #(
    .COORD_BITS(CoordBits)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .byte_in(byte_in),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .write_cell(write_cell),
    .cell_index(cell_index),
    .glyph(glyph),
    .attribute(attribute),
    .scroll_up(scroll_up),
    .cursor_column(cursor_column),
    .cursor_line(cursor_line)
  );

  always #5 clk = ~clk;

  // terminal state mirror
  logic [7:0] scr_cols;
  logic [7:0] scr_rows;
  phase_t     esc_ph;
  logic [6:0] sgr_code;
  logic       sgr_closed;
  logic [3:0] fg_color;
  logic [3:0] bg_color;
  logic [7:0] cur_col;
  logic [7:0] cur_row;

  screen_update_t pending[$];
  int sent_bytes = 0;
  int checked = 0;
  int mismatches = 0;
  int cell_writes = 0;
  int scrolls = 0;
  int idle_cycles = 0;
  int next_hold = 400;
  bit in_fast = 1'b0;
  bit out_fast = 1'b0;

  function automatic void apply_color(input logic [6:0] code);
    logic [3:0] t;
    if (code == 0 || code == 22) begin
      fg_color = FG_RESET;
      bg_color = BG_RESET;
    end else if (code == 1) begin
      fg_color = fg_color | 4'd8;
    end else if (code == 2 || code == 21) begin
      fg_color = fg_color & 4'd7;
    end else if (code == 7 || code == 27) begin
      t = fg_color;
      fg_color = bg_color;
      bg_color = t;
    end else if (code == 39) begin
      fg_color = FG_RESET;
    end else if (code == 49) begin
      bg_color = BG_RESET;
    end else if (code >= 30 && code <= 37) begin
      fg_color = SgrToVga[code - 30];
    end else if (code >= 40 && code <= 47) begin
      bg_color = SgrToVga[code - 40];
    end else if (code >= 90 && code <= 97) begin
      fg_color = SgrToVga[code - 90] | 4'd8;
    end else if (code >= 100 && code <= 107) begin
      bg_color = SgrToVga[code - 100] | 4'd8;
    end
  endfunction

  function automatic screen_update_t term_advance(input logic [7:0] b);
    screen_update_t upd;
    int cols;
    int nrows;
    int x;
    int y;
    int v;
    bit show;
    bit moved;
    upd = '0;
    cols = (scr_cols == 0) ? 1 : int'(scr_cols);
    nrows = (scr_rows == 0) ? 1 : int'(scr_rows);
    x = cur_col;
    y = cur_row;
    show = 1'b0;
    moved = 1'b0;
    case (esc_ph)
      PH_ESC: begin
        if (b == CH_LBRACKET) begin
          esc_ph = PH_CSI;
          sgr_code = '0;
          sgr_closed = 1'b0;
        end else begin
          esc_ph = PH_NORMAL;
          show = 1'b1;
        end
      end
      PH_CSI: begin
        if (b >= FINAL_LO && b <= FINAL_HI) begin
          if (b == CH_M) apply_color(sgr_code);
          esc_ph = PH_NORMAL;
        end else if (b >= CH_ZERO && b <= CH_NINE && !sgr_closed) begin
          v = int'(sgr_code) * 10 + int'(b) - int'(CH_ZERO);
          sgr_code = (v > 127) ? PARAM_MAX : v[6:0];
        end else begin
          sgr_closed = 1'b1;
        end
      end
      default: begin
        esc_ph = PH_NORMAL;
        show = 1'b1;
      end
    endcase
    if (show) begin
      if (b == CH_NUL) begin
      end else if (b == CH_ESC) begin
        esc_ph = PH_ESC;
        sgr_code = '0;
        sgr_closed = 1'b0;
      end else if (b == CH_TAB) begin
        x = (x + 8) & ~7;
        moved = 1'b1;
      end else if (b == CH_NL) begin
        x = 0;
        y = y + 1;
        moved = 1'b1;
      end else begin
        upd.wr = 1'b1;
        upd.idx = 16'(x + y * cols);
        upd.gl = b;
        upd.at = {bg_color, fg_color};
        x = x + 1;
        moved = 1'b1;
      end
    end
    if (moved) begin
      if (x >= cols || x > CoordMax) begin
        x = 0;
        y = y + 1;
      end
      if (y >= nrows || y > CoordMax) begin
        y = nrows - 1;
        if (y > CoordMax) y = CoordMax;
        upd.scr = 1'b1;
      end
      cur_col = x[7:0];
      cur_row = y[7:0];
    end
    upd.ccol = cur_col;
    upd.crow = cur_row;
    return upd;
  endfunction

  function automatic string upd_str(input screen_update_t t);
    return $sformatf("wr=%0b idx=%0d glyph=%02h attr=%02h scroll=%0b col=%0d row=%0d",
                     t.wr, t.idx, t.gl, t.at, t.scr, t.ccol, t.crow);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic typed, input screen_update_t lit);
    int gap;
    screen_update_t pred;
    if (sent_bytes % 40 == 0) in_fast = ($urandom_range(0, 3) == 0);
    gap = in_fast ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    byte_in <= b;
    do @(posedge clk); while (!in_ready);
    pred = term_advance(b);
    pending.push_back(typed ? lit : pred);
    sent_bytes++;
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_COLUMNS) scr_cols = val;
    else if (idx == CFG_ROWS) scr_rows = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
  endtask

  task automatic emit_chunk(input int nl_pct, inout int n);
    int sel;
    int code;
    logic [7:0] seq[$];
    sel = $urandom_range(0, 99);
    if (sel < nl_pct) begin
      seq.push_back(CH_NL);
    end else if (sel < nl_pct + 8) begin
      seq.push_back(CH_TAB);
    end else if (sel < nl_pct + 28) begin
      seq.push_back(CH_ESC);
      if ($urandom_range(0, 9) == 0) begin
        seq.push_back(8'($urandom_range(0, 255)));
      end else begin
        seq.push_back(CH_LBRACKET);
        case ($urandom_range(0, 5))
          0: code = SgrSpecial[$urandom_range(0, 8)];
          1: code = 30 + $urandom_range(0, 9);
          2: code = 40 + $urandom_range(0, 9);
          3: code = 90 + $urandom_range(0, 9);
          4: code = 100 + $urandom_range(0, 9);
          default: code = $urandom_range(0, 999);
        endcase
        if (code != 0 || $urandom_range(0, 1) == 1) begin
          if (code >= 100) seq.push_back(8'(CH_ZERO + code / 100));
          if (code >= 10) seq.push_back(8'(CH_ZERO + (code / 10) % 10));
          seq.push_back(8'(CH_ZERO + code % 10));
        end
        if ($urandom_range(0, 3) == 0) begin
          seq.push_back(8'($urandom_range(8'h20, 8'h3F)));
          if ($urandom_range(0, 1) == 1) seq.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 4) != 0) seq.push_back(CH_M);
        else seq.push_back(8'($urandom_range(FINAL_LO, FINAL_HI)));
      end
    end else if (sel < nl_pct + 64) begin
      seq.push_back(8'($urandom_range(8'h20, 8'h7E)));
    end else begin
      seq.push_back(8'($urandom_range(0, 255)));
    end
    foreach (seq[k]) send_byte(seq[k], 1'b0, NO_UPD);
    n += seq.size();
  endtask

  initial begin
    int n;
    int c;
    int r;
    rst = 1'b1;
    in_valid = 1'b0;
    byte_in = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    scr_cols = COLUMNS_RESET;
    scr_rows = ROWS_RESET;
    esc_ph = PH_NORMAL;
    sgr_code = '0;
    sgr_closed = 1'b0;
    fg_color = FG_RESET;
    bg_color = BG_RESET;
    cur_col = '0;
    cur_row = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DirRows; i++) send_byte(DIR_TAB[i].b, DIR_TAB[i].has_exp, DIR_TAB[i].exp);

    for (int ph = 0; ph < NumPhases; ph++) begin
      settle();
      c = (PhaseCols[ph] < 0) ? $urandom_range(1, 255) : PhaseCols[ph];
      r = (PhaseRows[ph] < 0) ? $urandom_range(1, 255) : PhaseRows[ph];
      write_reg(CFG_COLUMNS, 8'(c));
      write_reg(CFG_ROWS, 8'(r));
      n = 0;
      while (n < PhaseBytes) emit_chunk(PhaseNl[ph], n);
    end
    settle();
    repeat (20) @(posedge clk);

    $display("%0d bytes over %0d screen sizes (1x1 to 255x255, zero sizes too), %0d results checked",
             sent_bytes, NumPhases, checked);
    $display("%0d cell writes, %0d scroll requests, output held off twice to back up the input",
             cell_writes, scrolls);
    if (mismatches == 0 && pending.size() == 0) begin
      $display("text_terminal_with_ansi_color regression: pass");
    end else begin
      $display("text_terminal_with_ansi_color regression: fail");
    end
    $finish;
  end

  initial begin
    int stall;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (checked % 40 == 0) out_fast = ($urandom_range(0, 3) == 0);
      stall = out_fast ? 0 : $urandom_range(0, 6);
      if (checked >= next_hold) begin
        stall = HoldCycles;
        next_hold += 800;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    screen_update_t got;
    screen_update_t want;
    if (!rst && out_valid && out_ready) begin
      got = {write_cell, cell_index, glyph, attribute, scroll_up, cursor_column, cursor_line};
      if (got.wr === 1'b1) cell_writes++;
      if (got.scr === 1'b1) scrolls++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("beat %0d with nothing expected: %s", checked, upd_str(got));
      end else begin
        want = pending.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("beat %0d mismatch\n  exp %s\n  got %s", checked, upd_str(want), upd_str(got));
          end
        end
      end
      checked++;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               idle_cycles, pending.size());
      $display("text_terminal_with_ansi_color regression: fail");
      $finish;
    end
  end

endmodule
